/* hdl/rtlts_pkg.sv */
// Shared types and constants of the recency table block.
package rtlts_pkg;

   localparam int ENTRIES    = 8;
   localparam int SLOT_W     = 3;
   localparam int CNT_W      = 4;
   localparam int ID_W       = 8;
   localparam int TS_W       = 32;
   localparam int UCNT_W     = 8;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [UCNT_W-1:0]       COUNT_MAX   = UCNT_W'(255);
   localparam logic [TS_W-1:0]         LIMIT_RESET = TS_W'(60);
   localparam logic [CSR_ADDR_W-3:0]   REG_LIMIT   = '0;

   typedef enum logic [2:0] {
      ACT_ADD     = 3'd0,
      ACT_ADD_PIN = 3'd1,
      ACT_REMOVE  = 3'd2,
      ACT_AGE     = 3'd3,
      ACT_CLR_PIN = 3'd4,
      ACT_LIST    = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_SORT_LOAD,
      ST_SORT_STEP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   id;
      logic [TS_W-1:0]   stamp;
      logic [UCNT_W-1:0] uses;
      logic              pinned;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   id;
      logic [TS_W-1:0]   stamp;
      logic [UCNT_W-1:0] uses;
      logic              pinned;
      logic              found;
      logic              evicted;
      logic [CNT_W-1:0]  count;
      logic              last;
   } result_type;

endpackage

/* hdl/recency_table_lru_timestamp_core.sv */
// Top level of the recency table: entry chain, sort chain, control and ports.
//
// Usage: a request on req_* carries an action, an id and the current time.
// The table is a ring of eight entry cells that rotates once per scanned
// request, so each scan passes through one head unit with one 32-bit
// subtract and two 32-bit compares. Add, remove, age-out and clear-pinned
// give one response after acceptance, the scan, a resolve step and the
// output register. Negative ids on add or remove and unknown actions answer
// without a scan. List copies the valid entries into a second chain
// during the scan, then runs one exchange pass per response; rsp_tlast
// marks the final response. A new request is taken once the previous one
// has put its final response into the output register, even if that
// response is still waiting. If rsp_tready stays low, one response waits
// in the output register and the block holds its next response back until
// it is taken. Reset empties the table, drops any pending response and
// sets inactivity_limit to 60; there is no clearing pass. csr_* is an
// APB-style port for inactivity_limit at 0x0.
module recency_table_lru_timestamp_core
   import rtlts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] action, [11:3] item_id, [43:12] now_time, [47:44] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] slot, [10:3] entry_id, [42:11] entry_time, [50:43] entry_count,
   // [51] entry_pinned, [52] found, [53] evicted, [57:54] count, [63:58] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int RSP_PAD_W = RSP_DATA_W - (SLOT_W + ID_W + TS_W + UCNT_W + 3 + CNT_W);

   function automatic logic [RSP_DATA_W-1:0] pack_result(result_type r);
      return {{RSP_PAD_W{1'b0}}, r.count, r.evicted, r.found, r.pinned,
              r.uses, r.stamp, r.id, r.slot};
   endfunction

   // request fields
   action_type        req_act;
   logic              req_neg;
   logic [ID_W-1:0]   req_id;
   logic [TS_W-1:0]   req_now;
   logic              req_bad;

   // control registers
   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TS_W-1:0]   now_ff, now_in;
   logic [TS_W-1:0]   limit_ff, limit_in;
   logic [SLOT_W-1:0] step_ff, step_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] sel_ff, sel_in;
   entry_type         cap_ff, cap_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic [SLOT_W-1:0] old_ff, old_in;
   logic [TS_W-1:0]   old_ts_ff, old_ts_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  stp_ff, stp_in;
   entry_type         car_ff, car_in;
   result_type        res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   // chains
   entry_type         tbl_q   [ENTRIES];
   entry_type         tbl_nbr [ENTRIES];
   cell_ctrl_type     tbl_ctrl[ENTRIES];
   entry_type         srt_q   [ENTRIES];
   entry_type         srt_nbr [ENTRIES];
   cell_ctrl_type     srt_ctrl[ENTRIES];
   entry_type         tbl_wr_d;
   entry_type         srt_ld_d;

   // control outputs
   logic              tbl_shift, tbl_write, srt_shift, srt_append, srt_tail, emit_go;
   logic              out_free, list_emit;

   // head unit and resolve logic
   entry_type         head, head_out, append_e, loser, fresh, base, upd;
   logic              hit_id, drop, greater, blank_cnt;
   logic [TS_W-1:0]   age;
   logic [SLOT_W-1:0] wr_slot;
   logic [CNT_W-1:0]  tail_idx;
   result_type        blank_res, car_res, out_res;

   assign req_act = action_type'(req_tdata[2:0]);
   assign req_neg = req_tdata[11];
   assign req_id  = req_tdata[10:3];
   assign req_now = req_tdata[43:12];

   always_comb begin
      unique case (req_act)
         ACT_ADD, ACT_ADD_PIN, ACT_REMOVE: req_bad = req_neg;
         ACT_AGE, ACT_CLR_PIN, ACT_LIST:   req_bad = 1'b0;
         default:                          req_bad = 1'b1;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign list_emit = (act_ff == ACT_LIST) && (n_ff != '0);
   assign tail_idx  = rem_ff - CNT_W'(1);

   // ---------------------------------------------------------------- head
   assign head    = tbl_q[0];
   assign hit_id  = head.valid && (head.id == id_ff);
   assign age     = now_ff - head.stamp;

   always_comb begin
      unique case (act_ff)
         ACT_REMOVE:  drop = hit_id && !head.pinned;
         ACT_AGE:     drop = head.valid && (age > limit_ff);
         ACT_CLR_PIN: drop = head.valid && head.pinned;
         default:     drop = 1'b0;
      endcase
   end

   always_comb begin
      head_out       = head;
      head_out.valid = head.valid && !drop;
      append_e       = head;
      append_e.slot  = step_ff;
   end

   // ---------------------------------------------------------------- sort step
   assign greater = srt_q[0].stamp > car_ff.stamp;
   assign loser   = greater ? car_ff : srt_q[0];
   assign srt_ld_d = (state_ff == ST_SCAN) ? append_e : loser;

   // ---------------------------------------------------------------- add resolve
   always_comb begin
      wr_slot = found_ff ? sel_ff : (free_ff ? free_slot_ff : old_ff);
      fresh        = '0;
      fresh.valid  = 1'b1;
      fresh.id     = id_ff;
      fresh.stamp  = now_ff;
      base         = found_ff ? cap_ff : fresh;
      upd          = base;
      upd.slot     = wr_slot;
      if (act_ff == ACT_ADD_PIN) begin
         upd.pinned = 1'b1;
         upd.uses   = '0;
         upd.stamp  = now_ff;
      end else if (!base.pinned) begin
         upd.uses   = (base.uses == COUNT_MAX) ? base.uses : base.uses + UCNT_W'(1);
         upd.stamp  = now_ff;
      end
      tbl_wr_d = upd;
   end

   always_comb begin
      blank_res      = '0;
      blank_res.last = 1'b1;
      car_res         = '0;
      car_res.slot    = car_ff.slot;
      car_res.id      = car_ff.id;
      car_res.stamp   = car_ff.stamp;
      car_res.uses    = car_ff.uses;
      car_res.pinned  = car_ff.pinned;
      car_res.found   = 1'b1;
      car_res.count   = n_ff;
      car_res.last    = (rem_ff == '0);
      out_res = list_emit ? car_res : res_ff;
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = req_bad ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ff == SLOT_W'(ENTRIES - 1)) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            state_in = list_emit ? ST_SORT_LOAD : ST_EMIT;
         end
         ST_SORT_LOAD: begin
            state_in = (rem_ff == CNT_W'(1)) ? ST_EMIT : ST_SORT_STEP;
         end
         ST_SORT_STEP: begin
            if (stp_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = (list_emit && rem_ff != '0) ? ST_SORT_LOAD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- controls
   always_comb begin
      req_tready = 1'b0;
      tbl_shift  = 1'b0;
      tbl_write  = 1'b0;
      srt_shift  = 1'b0;
      srt_append = 1'b0;
      srt_tail   = 1'b0;
      emit_go    = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_SCAN: begin
            tbl_shift  = 1'b1;
            srt_append = (act_ff == ACT_LIST) && head.valid;
         end
         ST_RESOLVE:   tbl_write = (act_ff == ACT_ADD) || (act_ff == ACT_ADD_PIN);
         ST_SORT_LOAD: srt_shift = 1'b1;
         ST_SORT_STEP: begin
            srt_shift = 1'b1;
            srt_tail  = 1'b1;
         end
         ST_EMIT:      emit_go = out_free;
         default:      req_tready = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      act_in       = act_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      sel_in       = sel_ff;
      cap_in       = cap_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      old_in       = old_ff;
      old_ts_in    = old_ts_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      stp_in       = stp_ff;
      car_in       = car_ff;
      res_in       = res_ff;
      blank_cnt    = 1'b0;

      if (req_tvalid && req_tready) begin
         act_in   = req_act;
         id_in    = req_id;
         now_in   = req_now;
         step_in  = '0;
         found_in = 1'b0;
         free_in  = 1'b0;
         n_in     = '0;
         res_in   = blank_res;
      end

      if (state_ff == ST_SCAN) begin
         step_in = step_ff + SLOT_W'(1);
         if (hit_id) begin
            found_in = 1'b1;
            sel_in   = step_ff;
            cap_in   = head;
         end
         if (!head.valid) begin
            free_in      = 1'b1;
            free_slot_in = step_ff;
         end
         // oldest entry, ties to the highest slot
         if (step_ff == '0 || head.stamp <= old_ts_ff) begin
            old_in    = step_ff;
            old_ts_in = head.stamp;
         end
         blank_cnt = drop && (act_ff == ACT_AGE || act_ff == ACT_CLR_PIN);
         if (blank_cnt || srt_append) begin
            n_in = n_ff + CNT_W'(1);
         end
      end

      if (state_ff == ST_RESOLVE) begin
         rem_in = n_ff;
         unique case (act_ff)
            ACT_ADD, ACT_ADD_PIN: begin
               res_in         = '0;
               res_in.slot    = wr_slot;
               res_in.id      = upd.id;
               res_in.stamp   = upd.stamp;
               res_in.uses    = upd.uses;
               res_in.pinned  = upd.pinned;
               res_in.found   = found_ff;
               res_in.evicted = !found_ff && !free_ff;
               res_in.last    = 1'b1;
            end
            ACT_REMOVE: begin
               res_in = blank_res;
               if (found_ff) begin
                  res_in.slot   = sel_ff;
                  res_in.id     = cap_ff.id;
                  res_in.stamp  = cap_ff.stamp;
                  res_in.uses   = cap_ff.uses;
                  res_in.pinned = cap_ff.pinned;
                  res_in.found  = 1'b1;
                  res_in.count  = cap_ff.pinned ? CNT_W'(0) : CNT_W'(1);
               end
            end
            ACT_AGE, ACT_CLR_PIN: begin
               res_in       = blank_res;
               res_in.count = n_ff;
            end
            default: res_in = blank_res;
         endcase
      end

      if (state_ff == ST_SORT_LOAD) begin
         car_in = srt_q[0];
         rem_in = rem_ff - CNT_W'(1);
         stp_in = rem_ff - CNT_W'(1);
      end

      if (state_ff == ST_SORT_STEP) begin
         stp_in = stp_ff - CNT_W'(1);
         if (greater) begin
            car_in = srt_q[0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pack_result(out_res);
         rsp_last_in  = out_res.last;
      end
   end

   // ---------------------------------------------------------------- csr
   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr[CSR_ADDR_W-1:2] == REG_LIMIT) begin
         limit_in = csr_pwdata;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_LIMIT) ? limit_ff : '0;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      id_ff        <= id_in;
      now_ff       <= now_in;
      step_ff      <= step_in;
      found_ff     <= found_in;
      sel_ff       <= sel_in;
      cap_ff       <= cap_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      old_ff       <= old_in;
      old_ts_ff    <= old_ts_in;
      n_ff         <= n_in;
      rem_ff       <= rem_in;
      stp_ff       <= stp_in;
      car_ff       <= car_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ---------------------------------------------------------------- chains
   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      if (k == ENTRIES - 1) begin : g_end
         assign tbl_nbr[k] = head_out;
         assign srt_nbr[k] = srt_q[k];
      end else begin : g_mid
         assign tbl_nbr[k] = tbl_q[k+1];
         assign srt_nbr[k] = srt_q[k+1];
      end

      assign tbl_ctrl[k].shift = tbl_shift;
      assign tbl_ctrl[k].load  = tbl_write && (wr_slot == SLOT_W'(k));
      assign srt_ctrl[k].shift = srt_shift;
      assign srt_ctrl[k].load  = (srt_append && (n_ff == CNT_W'(k))) ||
                                 (srt_tail && (tail_idx == CNT_W'(k)));

      rtlts_cell u_tbl (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (tbl_ctrl[k]),
         .nbr_d  (tbl_nbr[k]),
         .load_d (tbl_wr_d),
         .cell_q (tbl_q[k])
      );

      rtlts_cell u_srt (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (srt_ctrl[k]),
         .nbr_d  (srt_nbr[k]),
         .load_d (srt_ld_d),
         .cell_q (srt_q[k])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hdl/rtlts_cell.sv */
// One cell of an entry chain: loads from its neighbor on shift or from the load bus.
module rtlts_cell
   import rtlts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     nbr_d,
   input  entry_type     load_d,
   output entry_type     cell_q
);

   entry_type cell_ff, cell_in;

   always_comb begin
      priority if (ctrl.load) begin
         cell_in = load_d;
      end else if (ctrl.shift) begin
         cell_in = nbr_d;
      end else begin
         cell_in = cell_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;

endmodule
